/* hw/rtl/rgbhsl_pkg.sv */
// Types and constants shared by the RGB to HSL converter.
`timescale 1ns / 1ps

package rgbhsl_pkg;

	localparam int unsigned CHAN_W  = 8;
	localparam int unsigned HUE_W   = 9;
	localparam int unsigned PCT_W   = 7;
	localparam int unsigned SUM_W   = CHAN_W + 1;
	localparam int unsigned HNUM_W  = 17;
	localparam int unsigned SNUM_W  = 15;
	localparam int unsigned STEPS   = 3;

	typedef struct packed {
		logic [CHAN_W-1:0] red;
		logic [CHAN_W-1:0] green;
		logic [CHAN_W-1:0] blue;
	} pixel_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [PCT_W-1:0] saturation;
		logic [PCT_W-1:0] lightness;
	} hsl_t;

	typedef enum logic [1:0] {
		MAX_RED   = 2'd0,
		MAX_GREEN = 2'd1,
		MAX_BLUE  = 2'd2
	} max_sel_t;

	typedef struct packed {
		logic [HNUM_W-1:0] rem;
		logic [HUE_W-1:0]  q;
	} hdiv_t;

	typedef struct packed {
		logic [SNUM_W-1:0] rem;
		logic [PCT_W-1:0]  q;
	} sdiv_t;

endpackage

/* hw/rtl/rgb_to_hsl_converter_unit.sv */
// Pipelined RGB to HSL converter, top level.
`timescale 1ns / 1ps

// Converts one 8-bit RGB pixel per clock into hue (degrees, 0..359) and
// saturation and lightness (percent, 0..100), all truncated. Throughput is
// one beat per cycle while the output is not stalled. Stage 1 finds max/min
// and the dominant channel, stage 2 forms the exact numerators and
// denominators (lightness divides by 255 with a reciprocal trick), stages 3
// to 5 are a restoring divider that resolves three quotient bits of hue and
// up to three of saturation per stage.
// Bubbles collapse; the pipeline only stalls its input when every stage
// holds a beat and the output is stalled.
module rgb_to_hsl_converter_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pixel_valid,
	output logic               pixel_stall,
	input  rgbhsl_pkg::pixel_t pixel,
	output logic               hsl_valid,
	input  logic               hsl_stall,
	output rgbhsl_pkg::hsl_t   hsl
);

	function automatic rgbhsl_pkg::hdiv_t hue_steps(rgbhsl_pkg::hdiv_t x,
			logic [rgbhsl_pkg::CHAN_W-1:0] den, int hi);
		rgbhsl_pkg::hdiv_t y;
		logic [rgbhsl_pkg::HNUM_W-1:0] dsh;
		y = x;
		for (int i = 0; i < rgbhsl_pkg::STEPS; i++) begin
			dsh = rgbhsl_pkg::HNUM_W'(den) << (hi - i);
			if (y.rem >= dsh) begin
				y.rem = y.rem - dsh;
				y.q[hi-i] = 1'b1;
			end
		end
		return y;
	endfunction

	function automatic rgbhsl_pkg::sdiv_t sat_steps(rgbhsl_pkg::sdiv_t x,
			logic [rgbhsl_pkg::CHAN_W-1:0] den, int hi, int n);
		rgbhsl_pkg::sdiv_t y;
		logic [rgbhsl_pkg::SNUM_W-1:0] dsh;
		y = x;
		for (int i = 0; i < rgbhsl_pkg::STEPS; i++) begin
			if (i < n) begin
				dsh = rgbhsl_pkg::SNUM_W'(den) << (hi - i);
				if (y.rem >= dsh) begin
					y.rem = y.rem - dsh;
					y.q[hi-i] = 1'b1;
				end
			end
		end
		return y;
	endfunction

	logic rdy1, rdy2, rdy3, rdy4, rdy5;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// stage 1
	logic [rgbhsl_pkg::CHAN_W-1:0] mx, mn;
	rgbhsl_pkg::max_sel_t          sel;
	logic signed [rgbhsl_pkg::SUM_W-1:0] diff;

	logic [rgbhsl_pkg::CHAN_W-1:0]       d_s1;
	logic [rgbhsl_pkg::SUM_W-1:0]        s_s1;
	rgbhsl_pkg::max_sel_t                sel_s1;
	logic signed [rgbhsl_pkg::SUM_W-1:0] diff_s1;

	// stage 2
	logic signed [18:0]                dd, df60, hn;
	logic [rgbhsl_pkg::SNUM_W-1:0]     lx, lsum;
	logic [rgbhsl_pkg::CHAN_W-1:0]     sden;

	rgbhsl_pkg::hdiv_t              h_s2;
	rgbhsl_pkg::sdiv_t              sd_s2;
	logic [rgbhsl_pkg::CHAN_W-1:0]  hden_s2, sden_s2;
	logic [rgbhsl_pkg::PCT_W-1:0]   light_s2;
	logic                           gray_s2;

	// divider stages
	rgbhsl_pkg::hdiv_t              h_s3, h_s4, h_s5;
	rgbhsl_pkg::sdiv_t              sd_s3, sd_s4, sd_s5;
	logic [rgbhsl_pkg::CHAN_W-1:0]  hden_s3, sden_s3, hden_s4, sden_s4;
	logic [rgbhsl_pkg::PCT_W-1:0]   light_s3, light_s4, light_s5;
	logic                           gray_s3, gray_s4, gray_s5;

	assign rdy5 = !v_s5 || !hsl_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign pixel_stall = !rdy1;

	always_comb begin
		mx = (pixel.red > pixel.green) ? pixel.red : pixel.green;
		mx = (mx > pixel.blue) ? mx : pixel.blue;
		mn = (pixel.red < pixel.green) ? pixel.red : pixel.green;
		mn = (mn < pixel.blue) ? mn : pixel.blue;
		if (pixel.red == mx) begin
			sel  = rgbhsl_pkg::MAX_RED;
			diff = signed'({1'b0, pixel.green}) - signed'({1'b0, pixel.blue});
		end else if (pixel.green == mx) begin
			sel  = rgbhsl_pkg::MAX_GREEN;
			diff = signed'({1'b0, pixel.blue}) - signed'({1'b0, pixel.red});
		end else begin
			sel  = rgbhsl_pkg::MAX_BLUE;
			diff = signed'({1'b0, pixel.red}) - signed'({1'b0, pixel.green});
		end
	end

	always_comb begin
		dd   = signed'({11'd0, d_s1});
		df60 = signed'({{10{diff_s1[rgbhsl_pkg::SUM_W-1]}}, diff_s1}) * 19'sd60;
		case (sel_s1)
			rgbhsl_pkg::MAX_RED: begin
				hn = df60;
				if (hn < 0) begin
					hn = hn + dd * 19'sd360;
				end
			end
			rgbhsl_pkg::MAX_GREEN: hn = dd * 19'sd120 + df60;
			rgbhsl_pkg::MAX_BLUE:  hn = dd * 19'sd240 + df60;
			default:               hn = '0;
		endcase
		sden = (s_s1 < rgbhsl_pkg::SUM_W'(255)) ? s_s1[rgbhsl_pkg::CHAN_W-1:0]
			: rgbhsl_pkg::CHAN_W'(rgbhsl_pkg::SUM_W'(510) - s_s1);
		// floor(x/255) = (x + 1 + (x >> 8)) >> 8 over this range
		lx   = rgbhsl_pkg::SNUM_W'(s_s1) * rgbhsl_pkg::SNUM_W'(50);
		lsum = lx + rgbhsl_pkg::SNUM_W'(1) + (lx >> 8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= pixel_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			d_s1    <= mx - mn;
			s_s1    <= rgbhsl_pkg::SUM_W'(mx) + rgbhsl_pkg::SUM_W'(mn);
			sel_s1  <= sel;
			diff_s1 <= diff;
		end
		if (rdy2) begin
			h_s2.rem  <= hn[rgbhsl_pkg::HNUM_W-1:0];
			h_s2.q    <= '0;
			sd_s2.rem <= rgbhsl_pkg::SNUM_W'(d_s1) * rgbhsl_pkg::SNUM_W'(100);
			sd_s2.q   <= '0;
			hden_s2   <= d_s1;
			sden_s2   <= sden;
			light_s2  <= lsum[rgbhsl_pkg::SNUM_W-1:8];
			gray_s2   <= (d_s1 == '0);
		end
		if (rdy3) begin
			h_s3     <= hue_steps(h_s2, hden_s2, 8);
			sd_s3    <= sat_steps(sd_s2, sden_s2, 6, 3);
			hden_s3  <= hden_s2;
			sden_s3  <= sden_s2;
			light_s3 <= light_s2;
			gray_s3  <= gray_s2;
		end
		if (rdy4) begin
			h_s4     <= hue_steps(h_s3, hden_s3, 5);
			sd_s4    <= sat_steps(sd_s3, sden_s3, 3, 3);
			hden_s4  <= hden_s3;
			sden_s4  <= sden_s3;
			light_s4 <= light_s3;
			gray_s4  <= gray_s3;
		end
		if (rdy5) begin
			h_s5     <= hue_steps(h_s4, hden_s4, 2);
			sd_s5    <= sat_steps(sd_s4, sden_s4, 0, 1);
			light_s5 <= light_s4;
			gray_s5  <= gray_s4;
		end
	end

	// gray pixels: hue and saturation forced to zero
	assign hsl_valid      = v_s5;
	assign hsl.hue        = gray_s5 ? '0 : h_s5.q;
	assign hsl.saturation = gray_s5 ? '0 : sd_s5.q;
	assign hsl.lightness  = light_s5;

`ifndef SYNTHESIS
	a_hue_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid |-> hsl.hue < rgbhsl_pkg::HUE_W'(360))
		else $error("hue out of range");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		hsl_valid |-> (hsl.saturation <= rgbhsl_pkg::PCT_W'(100))
			&& (hsl.lightness <= rgbhsl_pkg::PCT_W'(100)))
		else $error("percent out of range");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_stall |-> v_s1 && v_s2 && v_s3 && v_s4 && hsl_valid && hsl_stall)
		else $error("input stalled with a bubble in the pipeline");

	a_hue_rem: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 && !gray_s5 |-> h_s5.rem < rgbhsl_pkg::HNUM_W'($past(hden_s4)) ||
			$past(!rdy5))
		else $error("hue divider remainder not reduced");
`endif

endmodule

/* bench/rgb_to_hsl_converter_unit_test.sv */
// Self-checking testbench for the RGB to HSL converter unit.
`timescale 1ns / 1ps

module rgb_to_hsl_converter_unit_test;

	localparam int RANDOM_PIXELS = 700;
	localparam int DRAIN_CYCLES  = 20;

	logic               clk         = 1'b0;
	logic               arst_n      = 1'b0;
	logic               pixel_valid = 1'b0;
	logic               pixel_stall;
	rgbhsl_pkg::pixel_t pixel       = '0;
	logic               hsl_valid;
	logic               hsl_stall   = 1'b0;
	rgbhsl_pkg::hsl_t   hsl;

	rgbhsl_pkg::pixel_t pending_pixels[$];
	rgbhsl_pkg::hsl_t   expected_hsl[$];
	int     total_pixels = 0;
	int     pixels_in    = 0;
	int     pixels_out   = 0;
	int     mismatches   = 0;
	int     gray_seen    = 0;
	int     tie_seen     = 0;
	logic   pixel_taken  = 1'b0;

	rgb_to_hsl_converter_unit u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.pixel_valid (pixel_valid),
		.pixel_stall (pixel_stall),
		.pixel       (pixel),
		.hsl_valid   (hsl_valid),
		.hsl_stall   (hsl_stall),
		.hsl         (hsl)
	);

	always #1 clk = ~clk;

	function automatic rgbhsl_pkg::hsl_t predict_hsl(input rgbhsl_pkg::pixel_t p);
		int               r, g, b, mx, mn, d, s, num;
		rgbhsl_pkg::hsl_t res;
		r = p.red;
		g = p.green;
		b = p.blue;
		mx = (r > g) ? r : g;
		mx = (mx > b) ? mx : b;
		mn = (r < g) ? r : g;
		mn = (mn < b) ? mn : b;
		d = mx - mn;
		s = mx + mn;
		res = '0;
		res.lightness = rgbhsl_pkg::PCT_W'((50 * s) / 255);
		if (d != 0) begin
			res.saturation = (s < 255) ? rgbhsl_pkg::PCT_W'((100 * d) / s)
				: rgbhsl_pkg::PCT_W'((100 * d) / (510 - s));
			if (r == mx) begin
				num = 60 * (g - b);
				if (num < 0)
					num += 360 * d;
			end else if (g == mx) begin
				num = 120 * d + 60 * (b - r);
			end else begin
				num = 240 * d + 60 * (r - g);
			end
			res.hue = rgbhsl_pkg::HUE_W'(num / d);
		end
		return res;
	endfunction

	function automatic int sender_idle_pct(input int done);
		case ((done * 3) / (total_pixels + 1))
			0: return 29;
			1: return 52;
			default: return 0;
		endcase
	endfunction

	function automatic int receiver_idle_pct(input int done);
		case ((done * 3) / (total_pixels + 1))
			0: return 52;
			1: return 29;
			default: return 0;
		endcase
	endfunction

	task automatic add_pixel(input int r, input int g, input int b);
		rgbhsl_pkg::pixel_t p;
		p.red = rgbhsl_pkg::CHAN_W'(r);
		p.green = rgbhsl_pkg::CHAN_W'(g);
		p.blue = rgbhsl_pkg::CHAN_W'(b);
		pending_pixels.push_back(p);
	endtask

	// driver: a stalled beat holds until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!pixel_valid || pixel_taken) begin
				if (pending_pixels.size() != 0 &&
				    $urandom_range(99) >= sender_idle_pct(pixels_in)) begin
					pixel <= pending_pixels.pop_front();
					pixel_valid <= 1'b1;
				end else begin
					pixel_valid <= 1'b0;
				end
			end
			hsl_stall <= ($urandom_range(99) < receiver_idle_pct(pixels_in));
		end
	end

	// monitor: both channels sampled at the rising edge
	always @(posedge clk) begin
		rgbhsl_pkg::hsl_t want;
		pixel_taken = pixel_valid && !pixel_stall;
		if (pixel_taken) begin
			expected_hsl.push_back(predict_hsl(pixel));
			pixels_in++;
			if (pixel.red == pixel.green && pixel.green == pixel.blue)
				gray_seen++;
			else if (pixel.red == pixel.green || pixel.green == pixel.blue ||
			         pixel.red == pixel.blue)
				tie_seen++;
		end
		if (hsl_valid && !hsl_stall) begin
			pixels_out++;
			if (expected_hsl.size() == 0) begin
				$error("hsl beat with no pixel pending: hue %0d sat %0d light %0d",
				       hsl.hue, hsl.saturation, hsl.lightness);
				mismatches++;
			end else begin
				want = expected_hsl.pop_front();
				if (hsl.hue !== want.hue) begin
					$error("hue: expected %0d, got %0d", want.hue, hsl.hue);
					mismatches++;
				end
				if (hsl.saturation !== want.saturation) begin
					$error("saturation: expected %0d, got %0d", want.saturation,
					       hsl.saturation);
					mismatches++;
				end
				if (hsl.lightness !== want.lightness) begin
					$error("lightness: expected %0d, got %0d", want.lightness,
					       hsl.lightness);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int k, r, g, b, c;
		// extremes, grays, pure primaries, ties for max, hue wrap, saturation split at 255
		add_pixel(0, 0, 0);
		add_pixel(255, 255, 255);
		add_pixel(128, 128, 128);
		add_pixel(255, 0, 0);
		add_pixel(0, 255, 0);
		add_pixel(0, 0, 255);
		add_pixel(255, 255, 0);
		add_pixel(0, 255, 255);
		add_pixel(255, 0, 255);
		add_pixel(200, 100, 200);
		add_pixel(90, 90, 30);
		add_pixel(255, 0, 1);
		add_pixel(255, 1, 0);
		add_pixel(200, 55, 55);
		add_pixel(254, 0, 0);
		add_pixel(255, 1, 1);
		add_pixel(1, 0, 0);
		add_pixel(0, 0, 1);
		add_pixel(0, 1, 0);
		add_pixel(255, 254, 254);
		add_pixel(254, 255, 254);
		add_pixel(10, 20, 200);
		add_pixel(170, 85, 0);
		add_pixel(37, 201, 113);
		for (int i = 0; i < RANDOM_PIXELS; i++) begin
			k = $urandom_range(99);
			r = $urandom_range(255);
			g = $urandom_range(255);
			b = $urandom_range(255);
			if (k < 15) begin
				g = r;
				b = r;
			end else if (k < 35) begin
				c = $urandom_range(r);
				case ($urandom_range(2))
					0: begin g = r; b = c; end
					1: begin b = r; g = c; end
					default: begin g = r; b = r; r = c; end
				endcase
			end else if (k < 45) begin
				r = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 255 : r);
				g = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 255 : g);
				b = ($urandom_range(2) == 0) ? 0 : (($urandom_range(1) == 0) ? 255 : b);
			end
			add_pixel(r, g, b);
		end
		total_pixels = pending_pixels.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		do @(negedge clk); while (pixels_in != total_pixels || expected_hsl.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d pixels converted (%0d gray, %0d with tied channels)",
		         pixels_out, gray_seen, tie_seen);
		$display("under three pacing phases of sender and receiver idling");
		if (mismatches == 0)
			$display("rgb_to_hsl_converter_unit test passed");
		else
			$display("rgb_to_hsl_converter_unit test failed");
		$finish;
	end

	initial begin
		#200000;
		$display("rgb_to_hsl_converter_unit test failed");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/rgbhsl_pkg.sv
hw/rtl/rgb_to_hsl_converter_unit.sv
bench/rgb_to_hsl_converter_unit_test.sv
